### design/wrc_pkg.sv
package wrc_pkg;

    localparam int MaxWindow = 16;
    localparam int LineW     = 4;
    localparam int ValueW    = 32;
    localparam int PosW      = 12;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 12;
    localparam int WinSizeW  = 5;

    localparam logic [CfgIdxW-1:0] CfgWinSize = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgRowBase = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgColBase = 2'd2;

    localparam logic KindRow = 1'b0;
    localparam logic KindCol = 1'b1;

    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic [LineW-1:0]         offset;
    } t_col_entry;

    typedef struct packed {
        logic                     kind;
        logic [LineW-1:0]         line_number;
        logic signed [ValueW-1:0] min_value;
        logic [PosW-1:0]          min_position;
        logic                     last;
    } t_result;

endpackage

### design/wrc_col_mem.sv
module wrc_col_mem (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [3:0]             i_wr_addr,
    input  wrc_pkg::t_col_entry    i_wr_data,
    input  logic                   i_rd_en,
    input  logic [3:0]             i_rd_addr,
    output wrc_pkg::t_col_entry    o_rd_data
);

    wrc_pkg::t_col_entry r_mem [wrc_pkg::MaxWindow];
    wrc_pkg::t_col_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/wrc_out_reg.sv
module wrc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wrc_pkg::t_result i_data,
    input  logic             i_stall,
    output logic             o_valid,
    output wrc_pkg::t_result o_data,
    output logic             o_free
);

    logic             r_valid;
    wrc_pkg::t_result r_data;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### design/window_row_col_minima_unit.sv
// Row and column minima of a square window of a distance matrix.
// Elements enter on the input channel (i_in_valid, o_in_stall, i_distance) in
// row-major order, one per transaction. The last element of each row yields a
// row result: its minimum value and absolute column. The last element of the
// window also yields one column result per column, in column order, with
// o_last set on the final one. Ties keep the earliest position.
// Throughput is one element per cycle within a window while the output is not
// stalled. The per-column minima live in a 16-entry memory with a registered
// read; an element reads its column entry as it is accepted and writes it back
// as it leaves the stage-1 register. A row result goes through the stage-1
// register and then the output register. After the last element of a window
// the input stalls while the column minima are read out after the row result,
// one per cycle while the output is not stalled, via the memory read register.
// The output is a single register: when i_out_stall is high the result held
// there stays, and the input stalls once an element has a result to emit.
// Reset restores win_size 1, both bases 0 and empty pipeline stages; the memory is not cleared,
// as the first row always writes every column entry. A configuration write to win_size or a base
// restarts the window; the user makes it only while the block is idle, which the block does not enforce.
module window_row_col_minima_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [wrc_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [wrc_pkg::CfgDataW-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [wrc_pkg::ValueW-1:0]   i_distance,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_kind,
    output logic [wrc_pkg::LineW-1:0]           o_line_number,
    output logic signed [wrc_pkg::ValueW-1:0]   o_min_value,
    output logic [wrc_pkg::PosW-1:0]            o_min_position,
    output logic                                o_last
);

    logic [wrc_pkg::WinSizeW-1:0] r_win_size;
    logic [wrc_pkg::PosW-1:0]     r_row_base;
    logic [wrc_pkg::PosW-1:0]     r_col_base;
    logic [3:0]                   last_idx;
    logic [wrc_pkg::WinSizeW-1:0] size_m1;

    logic [3:0] r_row_cnt;
    logic [3:0] r_col_cnt;
    logic [3:0] row_now;
    logic [3:0] col_now;
    logic       accept;

    logic                            r_s1_valid;
    logic signed [wrc_pkg::ValueW-1:0] r_s1_value;
    logic [3:0]                      r_s1_row;
    logic [3:0]                      r_s1_col;
    logic                            r_s1_row_end;
    logic                            r_s1_win_end;
    logic                            s1_adv;

    logic signed [wrc_pkg::ValueW-1:0] r_row_best;
    logic [3:0]                      r_row_off;
    logic signed [wrc_pkg::ValueW-1:0] n_row_best;
    logic [3:0]                      n_row_off;
    wrc_pkg::t_col_entry             rd_entry;
    wrc_pkg::t_col_entry             n_col_entry;

    logic       r_dump_busy;
    logic [3:0] r_dump_idx;
    logic       r_d1_valid;
    logic [3:0] r_d1_idx;
    logic       dump_issue;

    logic             mem_rd_en;
    logic [3:0]       mem_rd_addr;
    logic             out_load;
    logic             out_free_w;
    wrc_pkg::t_result out_data;
    wrc_pkg::t_result out_q;

    always_comb begin
        size_m1 = r_win_size - 5'd1;
        if (r_win_size == '0) begin
            last_idx = 4'd0;
        end else if (r_win_size > 5'(wrc_pkg::MaxWindow)) begin
            last_idx = 4'(wrc_pkg::MaxWindow - 1);
        end else begin
            last_idx = size_m1[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= 5'd1;
            r_row_base <= '0;
            r_col_base <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                wrc_pkg::CfgWinSize: begin
                    r_win_size <= i_cfg_data[wrc_pkg::WinSizeW-1:0];
                end
                wrc_pkg::CfgRowBase: begin
                    r_row_base <= i_cfg_data;
                end
                wrc_pkg::CfgColBase: begin
                    r_col_base <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign row_now = (r_row_cnt > last_idx) ? last_idx : r_row_cnt;
    assign col_now = (r_col_cnt > last_idx) ? last_idx : r_col_cnt;

    assign s1_adv     = r_s1_valid && (!r_s1_row_end || out_free_w);
    assign o_in_stall = r_dump_busy || r_d1_valid || (r_s1_valid && (r_s1_win_end || !s1_adv));
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index == wrc_pkg::CfgWinSize ||
                                     i_cfg_index == wrc_pkg::CfgRowBase ||
                                     i_cfg_index == wrc_pkg::CfgColBase)) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (accept) begin
            if (col_now == last_idx) begin
                r_col_cnt <= '0;
                r_row_cnt <= (row_now == last_idx) ? 4'd0 : row_now + 4'd1;
            end else begin
                r_col_cnt <= col_now + 4'd1;
                r_row_cnt <= row_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_value   <= i_distance;
            r_s1_row     <= row_now;
            r_s1_col     <= col_now;
            r_s1_row_end <= (col_now == last_idx);
            r_s1_win_end <= (col_now == last_idx) && (row_now == last_idx);
        end
    end

    always_comb begin
        if (r_s1_col == 4'd0 || r_s1_value < r_row_best) begin
            n_row_best = r_s1_value;
            n_row_off  = r_s1_col;
        end else begin
            n_row_best = r_row_best;
            n_row_off  = r_row_off;
        end
        if (r_s1_row == 4'd0 || r_s1_value < $signed(rd_entry.value)) begin
            n_col_entry.value  = r_s1_value;
            n_col_entry.offset = r_s1_row;
        end else begin
            n_col_entry = rd_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_best <= '0;
            r_row_off  <= '0;
        end else if (s1_adv) begin
            r_row_best <= n_row_best;
            r_row_off  <= n_row_off;
        end
    end

    assign dump_issue = r_dump_busy && (!r_d1_valid || out_free_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dump_busy <= 1'b0;
            r_dump_idx  <= '0;
            r_d1_valid  <= 1'b0;
        end else begin
            if (s1_adv && r_s1_win_end) begin
                r_dump_busy <= 1'b1;
                r_dump_idx  <= '0;
            end else if (dump_issue) begin
                r_dump_idx <= r_dump_idx + 4'd1;
                if (r_dump_idx == last_idx) begin
                    r_dump_busy <= 1'b0;
                end
            end
            if (dump_issue) begin
                r_d1_valid <= 1'b1;
            end else if (out_free_w) begin
                r_d1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (dump_issue) begin
            r_d1_idx <= r_dump_idx;
        end
    end

    assign mem_rd_en   = accept || dump_issue;
    assign mem_rd_addr = dump_issue ? r_dump_idx : col_now;

    wrc_col_mem u_col_mem (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (n_col_entry),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (rd_entry)
    );

    always_comb begin
        if (r_s1_valid) begin
            out_load              = s1_adv && r_s1_row_end;
            out_data.kind         = wrc_pkg::KindRow;
            out_data.line_number  = r_s1_row;
            out_data.min_value    = n_row_best;
            out_data.min_position = r_col_base + {8'd0, n_row_off};
            out_data.last         = 1'b0;
        end else begin
            out_load              = r_d1_valid;
            out_data.kind         = wrc_pkg::KindCol;
            out_data.line_number  = r_d1_idx;
            out_data.min_value    = rd_entry.value;
            out_data.min_position = r_row_base + {8'd0, rd_entry.offset};
            out_data.last         = (r_d1_idx == last_idx);
        end
    end

    wrc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_data  (out_data),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_q),
        .o_free  (out_free_w)
    );

    assign o_kind         = out_q.kind;
    assign o_line_number  = out_q.line_number;
    assign o_min_value    = out_q.min_value;
    assign o_min_position = out_q.min_position;
    assign o_last         = out_q.last;

endmodule

### dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [wrc_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
    localparam int MaxGap       = 13;
    localparam int RandomItems  = 430;
    localparam int SettleCycles = 6;
    localparam int PlanLen      = 31;

    typedef struct {
        bit                                is_cfg;
        logic [wrc_pkg::CfgIdxW-1:0]       idx;
        logic [wrc_pkg::CfgDataW-1:0]      data;
        logic signed [wrc_pkg::ValueW-1:0] sample;
        bit                                typed;
        wrc_pkg::t_result                  row_res;
        wrc_pkg::t_result                  col_res;
    } t_step;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_wr_en = 1'b0;
    logic [wrc_pkg::CfgIdxW-1:0]         i_cfg_index = '0;
    logic [wrc_pkg::CfgDataW-1:0]        i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic signed [wrc_pkg::ValueW-1:0]   i_distance = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic                                o_kind;
    logic [wrc_pkg::LineW-1:0]           o_line_number;
    logic signed [wrc_pkg::ValueW-1:0]   o_min_value;
    logic [wrc_pkg::PosW-1:0]            o_min_position;
    logic                                o_last;

    wrc_pkg::t_result minima_due[$];
    int      fail_count = 0;
    bit      in_gaps = 1'b1;
    bit      out_stalls = 1'b1;
    int      stall_left = 0;

    logic [wrc_pkg::WinSizeW-1:0]      win_reg = wrc_pkg::WinSizeW'(1);
    logic [wrc_pkg::PosW-1:0]          row_base_reg = '0;
    logic [wrc_pkg::PosW-1:0]          col_base_reg = '0;
    logic signed [wrc_pkg::ValueW-1:0] row_min = '0;
    logic [wrc_pkg::LineW-1:0]         row_min_off = '0;
    logic signed [wrc_pkg::ValueW-1:0] col_min [wrc_pkg::MaxWindow];
    logic [wrc_pkg::LineW-1:0]         col_min_off [wrc_pkg::MaxWindow];
    int                                row_idx = 0;
    int                                col_idx = 0;

    window_row_col_minima_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_distance     (i_distance),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_line_number  (o_line_number),
        .o_min_value    (o_min_value),
        .o_min_position (o_min_position),
        .o_last         (o_last)
    );

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end

    function automatic int side_of(logic [wrc_pkg::WinSizeW-1:0] w);
        if (w == 0) begin
            return 1;
        end
        if (w > wrc_pkg::MaxWindow) begin
            return wrc_pkg::MaxWindow;
        end
        return int'(w);
    endfunction

    function automatic void apply_config(logic [wrc_pkg::CfgIdxW-1:0] idx,
                                         logic [wrc_pkg::CfgDataW-1:0] data);
        case (idx)
            wrc_pkg::CfgWinSize: begin
                win_reg = data[wrc_pkg::WinSizeW-1:0];
            end
            wrc_pkg::CfgRowBase: begin
                row_base_reg = data[wrc_pkg::PosW-1:0];
            end
            wrc_pkg::CfgColBase: begin
                col_base_reg = data[wrc_pkg::PosW-1:0];
            end
            default: begin
                return;
            end
        endcase
        row_idx = 0;
        col_idx = 0;
    endfunction

    function automatic void add_due(wrc_pkg::t_result res);
        minima_due = {minima_due, res};
    endfunction

    // Typed results replace the computed ones; the running minima still advance.
    function automatic void predict_minima(logic signed [wrc_pkg::ValueW-1:0] v, bit typed,
                                           wrc_pkg::t_result row_res,
                                           wrc_pkg::t_result col_res);
        int               n;
        int               r;
        int               c;
        wrc_pkg::t_result res;
        n = side_of(win_reg);
        r = row_idx;
        c = col_idx;
        if (c == 0 || v < row_min) begin
            row_min = v;
            row_min_off = c[wrc_pkg::LineW-1:0];
        end
        if (r == 0 || v < col_min[c]) begin
            col_min[c] = v;
            col_min_off[c] = r[wrc_pkg::LineW-1:0];
        end
        if (c == n - 1) begin
            res.kind = wrc_pkg::KindRow;
            res.line_number = r[wrc_pkg::LineW-1:0];
            res.min_value = row_min;
            res.min_position = wrc_pkg::PosW'(col_base_reg + row_min_off);
            res.last = 1'b0;
            add_due(typed ? row_res : res);
            col_idx = 0;
            if (r == n - 1) begin
                for (int i = 0; i < n; i++) begin
                    res.kind = wrc_pkg::KindCol;
                    res.line_number = i[wrc_pkg::LineW-1:0];
                    res.min_value = col_min[i];
                    res.min_position = wrc_pkg::PosW'(row_base_reg + col_min_off[i]);
                    res.last = (i == n - 1);
                    add_due(typed ? col_res : res);
                end
                row_idx = 0;
            end else begin
                row_idx = r + 1;
            end
        end else begin
            col_idx = c + 1;
        end
    endfunction

    function automatic t_step cfg_step(logic [wrc_pkg::CfgIdxW-1:0] idx,
                                       logic [wrc_pkg::CfgDataW-1:0] data);
        t_step s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.data = data;
        return s;
    endfunction

    function automatic t_step elem_step(logic signed [wrc_pkg::ValueW-1:0] sample);
        t_step s;
        s = '{default: '0};
        s.sample = sample;
        return s;
    endfunction

    // A one-element window: the row result and the single column result.
    function automatic t_step typed_step(logic signed [wrc_pkg::ValueW-1:0] sample,
                                         logic [wrc_pkg::PosW-1:0] col_pos,
                                         logic [wrc_pkg::PosW-1:0] row_pos);
        t_step s;
        s = elem_step(sample);
        s.typed = 1'b1;
        s.row_res.kind = wrc_pkg::KindRow;
        s.row_res.line_number = '0;
        s.row_res.min_value = sample;
        s.row_res.min_position = col_pos;
        s.row_res.last = 1'b0;
        s.col_res.kind = wrc_pkg::KindCol;
        s.col_res.line_number = '0;
        s.col_res.min_value = sample;
        s.col_res.min_position = row_pos;
        s.col_res.last = 1'b1;
        return s;
    endfunction

    function automatic logic signed [wrc_pkg::ValueW-1:0] pick_distance();
        int near_zero;
        near_zero = int'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 9))
            0: begin
                return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end
            1, 2, 3: begin
                return near_zero;
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    function automatic logic [wrc_pkg::CfgDataW-1:0] pick_base();
        if ($urandom_range(0, 3) == 0) begin
            return wrc_pkg::CfgDataW'(4095 - $urandom_range(0, 15));
        end
        return wrc_pkg::CfgDataW'($urandom_range(0, 4095));
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_distance(logic signed [wrc_pkg::ValueW-1:0] v, bit typed,
                                 wrc_pkg::t_result row_res, wrc_pkg::t_result col_res);
        int gap;
        gap = in_gaps ? $urandom_range(0, MaxGap) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_distance <= v;
        do @(posedge i_clk); while (o_in_stall);
        predict_minima(v, typed, row_res, col_res);
    endtask

    task automatic write_register(logic [wrc_pkg::CfgIdxW-1:0] idx,
                                  logic [wrc_pkg::CfgDataW-1:0] data);
        i_in_valid <= 1'b0;
        while (minima_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        apply_config(idx, data);
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && !i_out_stall) begin
            stall_left = out_stalls ? $urandom_range(0, MaxGap) : 0;
            i_out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= (stall_left != 0);
        end
    end

    always @(posedge i_clk) begin : check_minima
        wrc_pkg::t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (minima_due.size() == 0) begin
                $error("Unexpected transaction: kind %0d, line %0d, value %0d, position %0d",
                       o_kind, o_line_number, o_min_value, o_min_position);
                fail_count++;
            end else begin
                want = minima_due.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("line_number", want.line_number, o_line_number);
                check_field("min_value", want.min_value, o_min_value);
                check_field("min_position", want.min_position, o_min_position);
                check_field("last", want.last, o_last);
            end
        end
    end

    initial begin : stimulus
        t_step                        plan [0:PlanLen-1];
        wrc_pkg::t_result             none;
        logic [wrc_pkg::CfgDataW-1:0] data;
        int                           sent;
        int                           phase;
        int                           n;
        int                           count;
        none = '0;
        plan = '{
            typed_step(32'sh7FFF_FFFF, 12'd0, 12'd0),
            typed_step(32'sh8000_0000, 12'd0, 12'd0),
            cfg_step(wrc_pkg::CfgRowBase, 12'hFFF),
            cfg_step(wrc_pkg::CfgColBase, 12'hFFE),
            typed_step(32'sh0000_0000, 12'hFFE, 12'hFFF),
            cfg_step(wrc_pkg::CfgWinSize, 12'hFE0),
            typed_step(32'shFFFF_0000, 12'hFFE, 12'hFFF),
            cfg_step(wrc_pkg::CfgWinSize, 12'd2),
            cfg_step(wrc_pkg::CfgColBase, 12'hFFF),
            elem_step(32'shFFFF_FFFF),
            elem_step(32'shFFFF_FFFF),
            elem_step(32'shFFFF_FFFF),
            elem_step(32'shFFFF_FFFE),
            cfg_step(wrc_pkg::CfgWinSize, 12'd3),
            cfg_step(wrc_pkg::CfgRowBase, 12'd0),
            cfg_step(wrc_pkg::CfgColBase, 12'd100),
            elem_step(32'sh000A_0000),
            elem_step(32'sh0014_0000),
            elem_step(32'sh0005_0000),
            elem_step(32'sh0007_0000),
            cfg_step(wrc_pkg::CfgColBase, 12'd200),
            elem_step(32'sh0003_0000),
            elem_step(32'sh0003_0000),
            cfg_step(CfgUnused, 12'hABC),
            elem_step(32'sh0003_0000),
            elem_step(32'sh0001_0000),
            elem_step(32'sh0001_0000),
            elem_step(32'sh0001_0000),
            elem_step(32'sh0002_0000),
            elem_step(32'sh0000_0000),
            elem_step(32'sh0000_0000)
        };
        for (int i = 0; i < wrc_pkg::MaxWindow; i++) begin
            col_min[i] = '0;
            col_min_off[i] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                write_register(plan[k].idx, plan[k].data);
            end else begin
                send_distance(plan[k].sample, plan[k].typed, plan[k].row_res, plan[k].col_res);
            end
        end

        // Mostly whole windows; now and then a window is cut short and restarted.
        sent = 0;
        phase = 0;
        while (sent < RandomItems) begin
            in_gaps = ($urandom_range(0, 3) != 0);
            out_stalls = ($urandom_range(0, 3) != 0);
            data = wrc_pkg::CfgDataW'($urandom());
            if (phase == 2) begin
                data[wrc_pkg::WinSizeW-1:0] = wrc_pkg::WinSizeW'($urandom_range(16, 31));
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        data[wrc_pkg::WinSizeW-1:0] = '0;
                    end
                    1, 2: begin
                        data[wrc_pkg::WinSizeW-1:0] = wrc_pkg::WinSizeW'($urandom_range(5, 10));
                    end
                    default: begin
                        data[wrc_pkg::WinSizeW-1:0] = wrc_pkg::WinSizeW'($urandom_range(1, 4));
                    end
                endcase
            end
            write_register(wrc_pkg::CfgWinSize, data);
            if ($urandom_range(0, 2) != 0) begin
                write_register(wrc_pkg::CfgRowBase, pick_base());
            end
            if ($urandom_range(0, 2) != 0) begin
                write_register(wrc_pkg::CfgColBase, pick_base());
            end
            if ($urandom_range(0, 7) == 0) begin
                write_register(CfgUnused, wrc_pkg::CfgDataW'($urandom()));
            end
            n = side_of(win_reg);
            count = ((n > 8) ? 1 : $urandom_range(1, 3)) * n * n;
            if ($urandom_range(0, 5) == 0) begin
                count = $urandom_range(1, count);
            end
            for (int i = 0; i < count; i++) begin
                send_distance(pick_distance(), 1'b0, none, none);
            end
            sent += count;
            phase++;
        end

        i_in_valid <= 1'b0;
        while (minima_due.size() != 0) @(posedge i_clk);
        repeat (4 * SettleCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
